[hw/rtl/button_debounce_long_press_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the button debounce / long-press core
// Immediate-implication and next-cycle property wrappers; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_CORE_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define BDLP_ASSERT_SAME(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) \
        (ante) |-> (cons)) else $error("bdlp assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BDLP_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) \
        (ante) |=> (cons)) else $error("bdlp assertion failed");

`else

`define BDLP_ASSERT_SAME(label, clock, resetn, ante, cons)
`define BDLP_ASSERT_NEXT(label, clock, resetn, ante, cons)

`endif

`endif

[hw/rtl/bdlp_pkg.sv]
// ---------------------------------------------------------------------------
// bdlp_pkg
// Widths, register indexes and reset values for the debounce core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdlp_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned MS_CFG_W   = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned S_TDATA_W  = 40;  // raw_level + now_ms, byte padded
    localparam int unsigned M_TDATA_W  = 8;   // press_event, byte padded

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_MS   = 2'd0,
        CFG_LONG_PRESS_MS = 2'd1,
        CFG_ACTIVE_LOW    = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_idx_t;

    localparam logic [MS_CFG_W-1:0] DEBOUNCE_MS_RST   = 16'd30;
    localparam logic [MS_CFG_W-1:0] LONG_PRESS_MS_RST = 16'd800;
    localparam logic                ACTIVE_LOW_RST    = 1'b1;

endpackage

[hw/rtl/button_debounce_long_press_core.sv]
// ---------------------------------------------------------------------------
// button_debounce_long_press_core
// Debounces polled button samples and reports short and long presses.
// ---------------------------------------------------------------------------
//  Channel | Dir | Handshake            | Payload
//  --------+-----+----------------------+-----------------------------------
//  s_*     | in  | s_tvalid / s_tready  | tdata: raw_level[0], now_ms[32:1]
//  m_*     | out | m_tvalid / m_tready  | tdata: press_event[0]; tuser: long
//  cfg_*   | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data[15:0]
//
//  One poll per cycle while m_tready is high; each poll yields exactly one result.
//  The poll lands in an input register, then the debounce/press update
//  runs in one pass into the result register.
//  The state update sits in that single pass, so back-to-back polls see
//  the state left by the previous poll with no bubble.
//  A stalled result (m_tready low) holds the result register; one more
//  poll can still be taken into the input register before s_tready drops.
//  rst_n is asynchronous, active low; config registers return to 30 ms,
//  800 ms and active-low. cfg_ready is always high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "button_debounce_long_press_core_macros.svh"

module button_debounce_long_press_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    // poll input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [bdlp_pkg::S_TDATA_W-1:0]       s_tdata,   // [0] raw_level, [32:1] now_ms, pad

    // event output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [bdlp_pkg::M_TDATA_W-1:0]       m_tdata,   // [0] press_event, pad
    output logic                                 m_tuser,   // [0] long_press

    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bdlp_pkg::MS_CFG_W-1:0]        cfg_data
);

    // ---------------- configuration registers ----------------
    logic [bdlp_pkg::MS_CFG_W-1:0] debounce_ms_reg;
    logic [bdlp_pkg::MS_CFG_W-1:0] long_press_ms_reg;
    logic                          active_low_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg   <= bdlp_pkg::DEBOUNCE_MS_RST;
            long_press_ms_reg <= bdlp_pkg::LONG_PRESS_MS_RST;
            active_low_reg    <= bdlp_pkg::ACTIVE_LOW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bdlp_pkg::cfg_idx_t'(cfg_index))
                bdlp_pkg::CFG_DEBOUNCE_MS:   debounce_ms_reg   <= cfg_data;
                bdlp_pkg::CFG_LONG_PRESS_MS: long_press_ms_reg <= cfg_data;
                bdlp_pkg::CFG_ACTIVE_LOW:    active_low_reg    <= cfg_data[0];
                default:                     ;  // unmapped index: dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                          in_valid_reg;
    logic                          in_raw_reg;
    logic [bdlp_pkg::TIME_W-1:0]   in_now_reg;
    logic                          advance;     // result register can load
    logic                          fire;        // poll processed this cycle

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_raw_reg <= s_tdata[0];
            in_now_reg <= s_tdata[bdlp_pkg::TIME_W:1];
        end
    end

    // ---------------- debounce state ----------------
    logic                          last_raw_reg,       last_raw_next;
    logic                          accepted_level_reg, accepted_level_next;
    logic [bdlp_pkg::TIME_W-1:0]   edge_time_reg,      edge_time_next;
    logic [bdlp_pkg::TIME_W-1:0]   press_time_reg,     press_time_next;
    logic                          long_reported_reg,  long_reported_next;

    logic                          pressed_level;
    logic                          settled;
    logic                          held_long;
    logic [bdlp_pkg::TIME_W-1:0]   settle_dt;
    logic [bdlp_pkg::TIME_W-1:0]   hold_dt;
    logic                          ev_next;
    logic                          long_next;

    always_comb
    begin
        pressed_level       = !active_low_reg;
        last_raw_next       = in_raw_reg;
        edge_time_next      = (in_raw_reg != last_raw_reg) ? in_now_reg : edge_time_reg;
        accepted_level_next = accepted_level_reg;
        press_time_next     = press_time_reg;
        long_reported_next  = long_reported_reg;
        ev_next             = 1'b0;
        long_next           = 1'b0;

        // Elapsed times wrap modulo 2^32.
        settle_dt = in_now_reg - edge_time_next;
        hold_dt   = in_now_reg - press_time_reg;
        settled   = settle_dt >= {{(bdlp_pkg::TIME_W-bdlp_pkg::MS_CFG_W){1'b0}},
                                  debounce_ms_reg};
        held_long = hold_dt >= {{(bdlp_pkg::TIME_W-bdlp_pkg::MS_CFG_W){1'b0}},
                                long_press_ms_reg};

        if (settled)
        begin
            if (in_raw_reg != accepted_level_reg)
            begin
                accepted_level_next = in_raw_reg;
                if (in_raw_reg == pressed_level)
                begin
                    // new press: restart the hold timer
                    press_time_next    = in_now_reg;
                    long_reported_next = 1'b0;
                end
                else if (!long_reported_reg)
                begin
                    ev_next = 1'b1;  // release before long time: short press
                end
            end
            else if ((in_raw_reg == pressed_level) && !long_reported_reg && held_long)
            begin
                long_reported_next = 1'b1;
                ev_next            = 1'b1;
                long_next          = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg       <= 1'b1;
            accepted_level_reg <= 1'b1;
            edge_time_reg      <= '0;
            press_time_reg     <= '0;
            long_reported_reg  <= 1'b0;
        end
        else if (fire)
        begin
            last_raw_reg       <= last_raw_next;
            accepted_level_reg <= accepted_level_next;
            edge_time_reg      <= edge_time_next;
            press_time_reg     <= press_time_next;
            long_reported_reg  <= long_reported_next;
        end
    end

    // ---------------- result register ----------------
    logic out_valid_reg;
    logic out_ev_reg;
    logic out_long_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_ev_reg   <= ev_next;
            out_long_reg <= long_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bdlp_pkg::M_TDATA_W-1){1'b0}}, out_ev_reg};
    assign m_tuser  = out_long_reg;

    // ---------------- assertions ----------------
    // A long press is always reported as an event.
    `BDLP_ASSERT_SAME(a_long_is_event, clk, rst_n, m_tvalid && m_tuser, m_tdata[0])
    // Input side only stalls when a full result register is blocked.
    `BDLP_ASSERT_SAME(a_stall_cause, clk, rst_n, !s_tready, in_valid_reg && m_tvalid && !m_tready)
    // Reporting a long press marks it as sent for this hold.
    `BDLP_ASSERT_NEXT(a_long_marks, clk, rst_n, fire && long_next, long_reported_reg)
    // An accepted press rearms long-press reporting.
    `BDLP_ASSERT_NEXT(a_press_rearms, clk, rst_n,
        fire && settled && (in_raw_reg != accepted_level_reg) && (in_raw_reg == pressed_level),
        !long_reported_reg)

endmodule

[tb/button_debounce_long_press_core_tb.sv]
// ---------------------------------------------------------------------------
// button_debounce_long_press_core_tb
// Drives timestamped pin polls and register writes into the debounce core
// and checks every short/long press result against a local press predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_debounce_long_press_core_tb;

    import bdlp_pkg::*;

    localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no transfer at all
    localparam int unsigned POLLS_PHASE  = 104;   // random polls per config phase
    localparam int unsigned RAND_PHASES  = 8;
    localparam int unsigned DRAIN_CYCLES = 8;     // two-stage core, generous margin

    // one pending operation: either a register write or a pin poll
    typedef struct {
        bit                  is_cfg;
        cfg_idx_t            idx;
        logic [MS_CFG_W-1:0] data;
        logic                raw;
        logic [TIME_W-1:0]   now;
    } pending_op_t;

    typedef struct packed {
        logic press_event;
        logic long_press;
    } press_evt_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT-facing signals
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;

    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // [0] raw_level, [32:1] now_ms, zero pad

    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [0] press_event, zero pad
    logic                 m_tuser;          // [0] long_press

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_idx_t             cfg_index = CFG_DEBOUNCE_MS;
    logic [MS_CFG_W-1:0]  cfg_data  = '0;

    button_debounce_long_press_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: config copy plus the debounce/press state.
    // Config is updated when the write transfer is seen on the bus.
    // ------------------------------------------------------------------
    logic [MS_CFG_W-1:0] cfg_db = DEBOUNCE_MS_RST;
    logic [MS_CFG_W-1:0] cfg_lp = LONG_PRESS_MS_RST;
    logic                cfg_al = ACTIVE_LOW_RST;

    logic                pin_last      = 1'b1;
    logic                level_settled = 1'b1;
    logic [TIME_W-1:0]   edge_ms       = '0;
    logic [TIME_W-1:0]   press_ms      = '0;
    logic                long_done     = 1'b0;

    pending_op_t pending_ops[$];
    press_evt_t  expected_events[$];

    // sender idle / receiver stall odds, percent
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    int unsigned fail_count  = 0;
    int unsigned polls_done  = 0;
    int unsigned cfg_writes  = 0;
    int unsigned short_seen  = 0;
    int unsigned long_seen   = 0;
    int unsigned quiet_ticks = 0;

    // Stimulus-side view of the config, used only to shape sequences.
    logic [MS_CFG_W-1:0] plan_db = DEBOUNCE_MS_RST;
    logic [MS_CFG_W-1:0] plan_lp = LONG_PRESS_MS_RST;
    logic                plan_al = ACTIVE_LOW_RST;
    logic [TIME_W-1:0]   t_ms    = '0;
    int unsigned         queued_polls = 0;

    // One poll through the debouncer; returns the result it must produce.
    function automatic press_evt_t predict_poll(logic raw, logic [TIME_W-1:0] now);
        press_evt_t        r;
        logic              pressed_lvl;
        logic [TIME_W-1:0] since_edge;
        logic [TIME_W-1:0] held_for;
        r = '0;
        pressed_lvl = ~cfg_al;
        // any raw change restarts the settle window
        if (raw != pin_last)
        begin
            pin_last = raw;
            edge_ms  = now;
        end
        since_edge = now - edge_ms;
        held_for   = now - press_ms;
        if (since_edge >= TIME_W'(cfg_db))
        begin
            if (raw != level_settled)
            begin
                level_settled = raw;
                if (raw == pressed_lvl)
                begin
                    press_ms  = now;
                    long_done = 1'b0;
                end
                else if (!long_done)
                begin
                    r.press_event = 1'b1;   // release after a short hold
                end
            end
            else if (raw == pressed_lvl && !long_done && held_for >= TIME_W'(cfg_lp))
            begin
                long_done     = 1'b1;
                r.press_event = 1'b1;
                r.long_press  = 1'b1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one pending op at a time, poll or register write.
    // Accepted polls are predicted here, at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : driver
        pending_op_t op;
        logic        s_busy;
        logic        c_busy;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_events.push_back(predict_poll(s_tdata[0], s_tdata[TIME_W:1]));
                polls_done++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE_MS:   cfg_db = cfg_data;
                    CFG_LONG_PRESS_MS: cfg_lp = cfg_data;
                    CFG_ACTIVE_LOW:    cfg_al = cfg_data[0];
                    default:           ;   // unused index, no effect
                endcase
                cfg_writes++;
            end
            s_busy = s_tvalid && !s_tready;
            c_busy = cfg_valid && !cfg_ready;
            if (!s_busy && !c_busy)
            begin
                if (pending_ops.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    op = pending_ops.pop_front();
                    if (op.is_cfg)
                    begin
                        s_tvalid  <= 1'b0;
                        cfg_valid <= 1'b1;
                        cfg_index <= op.idx;
                        cfg_data  <= op.data;
                    end
                    else
                    begin
                        cfg_valid <= 1'b0;
                        s_tvalid  <= 1'b1;
                        s_tdata   <= {{(S_TDATA_W - TIME_W - 1){1'b0}}, op.now, op.raw};
                    end
                end
                else
                begin
                    s_tvalid  <= 1'b0;
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest expectation,
    // then pick the next m_tready at random.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        press_evt_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with no poll pending: ev=%0b long=%0b",
                                 $realtime, m_tdata[0], m_tuser);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (m_tdata[0] !== want.press_event || m_tuser !== want.long_press)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch exp ev=%0b long=%0b got ev=%0b long=%0b",
                                     $realtime, want.press_event, want.long_press,
                                     m_tdata[0], m_tuser);
                    end
                    if (want.press_event && want.long_press)
                        long_seen++;
                    else if (want.press_event)
                        short_seen++;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: too long with no transfer on any channel means a hang.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_ticks <= 0;
            else
                quiet_ticks <= quiet_ticks + 1;
            if (quiet_ticks >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", quiet_ticks);
                $display("button_debounce_long_press_core_tb: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. All pending-op pushes happen on the falling edge.
    // ------------------------------------------------------------------
    task automatic wait_idle();
        @(negedge clk);
        while (pending_ops.size() != 0 || s_tvalid || cfg_valid || expected_events.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [MS_CFG_W-1:0] val);
        pending_op_t op;
        op.is_cfg = 1'b1;
        op.idx    = idx;
        op.data   = val;
        op.raw    = 1'b0;
        op.now    = '0;
        pending_ops.push_back(op);
        case (idx)
            CFG_DEBOUNCE_MS:   plan_db = val;
            CFG_LONG_PRESS_MS: plan_lp = val;
            CFG_ACTIVE_LOW:    plan_al = val[0];
            default:           ;
        endcase
    endtask

    task automatic poll(logic raw, logic [TIME_W-1:0] now);
        pending_op_t op;
        op.is_cfg = 1'b0;
        op.idx    = CFG_DEBOUNCE_MS;
        op.data   = '0;
        op.raw    = raw;
        op.now    = now;
        pending_ops.push_back(op);
        t_ms = now;
        queued_polls++;
    endtask

    // active_low write with random junk in the unused data bits
    task automatic write_polarity(logic al);
        write_reg(CFG_ACTIVE_LOW, {15'($urandom), al});
    endtask

    // Move to level lvl with some contact bounce, then hold it for about span ms.
    task automatic settle_to(logic lvl, int unsigned span);
        int unsigned nb;
        int unsigned k;
        nb = $urandom_range(0, 3);
        repeat (nb)
        begin
            poll(lvl, t_ms + $urandom_range(0, plan_db / 2));
            poll(~lvl, t_ms + $urandom_range(0, plan_db / 2));
        end
        poll(lvl, t_ms + $urandom_range(0, plan_db / 2));
        k = $urandom_range(1, 6);
        repeat (k)
            poll(lvl, t_ms + span / k + $urandom_range(0, 2));
    endtask

    // One full press/release with random bounce and hold length.
    task automatic press_cycle();
        logic        pressed_lvl;
        int unsigned hold;
        pressed_lvl = ~plan_al;
        case ($urandom_range(0, 2))
            0:       hold = 2 * (plan_db + plan_lp) + $urandom_range(1, 20);  // long hold
            1:       hold = plan_db + $urandom_range(0, plan_lp);             // short-ish
            default: hold = plan_db + plan_lp + $urandom_range(0, 4) - 2;      // near the line
        endcase
        settle_to(pressed_lvl, hold);
        settle_to(~pressed_lvl, plan_db + $urandom_range(0, 50));
    endtask

    // Random polls: jitter, jumps anywhere in time, and timestamps going backwards.
    task automatic noise_burst();
        int unsigned n;
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            case ($urandom_range(0, 2))
                0:       poll(1'($urandom), t_ms + $urandom_range(0, 3));
                1:       poll(1'($urandom), $urandom);
                default: poll(1'($urandom), t_ms - $urandom_range(1, 100));
            endcase
        end
    endtask

    function automatic logic [MS_CFG_W-1:0] pick_ms();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return MS_CFG_W'($urandom_range(1, 20));
            3:       return MS_CFG_W'($urandom_range(20, 1000));
            default: return MS_CFG_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned goal;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: pressed level at reset (active-high starts out pressed)
        wait_idle();
        write_polarity(1'b0);
        poll(1'b1, 32'd799);
        poll(1'b1, 32'd800);

        // directed: default timing, active low, settle boundary, wrap, out of order
        wait_idle();
        write_polarity(1'b1);
        poll(1'b1, 32'd0);
        poll(1'b0, 32'd5);
        poll(1'b0, 32'd34);
        poll(1'b0, 32'd35);
        poll(1'b0, 32'd834);
        poll(1'b0, 32'd835);
        poll(1'b1, 32'd836);
        poll(1'b1, 32'd866);
        poll(1'b0, 32'hFFFF_FFF0);
        poll(1'b0, 32'h0000_000E);
        poll(1'b1, 32'h0000_0010);
        poll(1'b1, 32'h0000_002E);
        poll(1'b1, 32'h0000_0003);
        poll(1'b0, 32'hFFFF_FFFF);

        // directed: zero debounce, zero long time, active high, unused index
        wait_idle();
        write_reg(CFG_DEBOUNCE_MS, '0);
        write_reg(CFG_LONG_PRESS_MS, '0);
        write_polarity(1'b0);
        write_reg(CFG_UNUSED, MS_CFG_W'($urandom));
        poll(1'b1, 32'h0000_0100);
        poll(1'b0, 32'h0000_0100);
        poll(1'b1, 32'h0000_0101);
        poll(1'b1, 32'h0000_0101);

        // directed: largest debounce and long time, exact boundary
        wait_idle();
        write_reg(CFG_DEBOUNCE_MS, '1);
        write_reg(CFG_LONG_PRESS_MS, '1);
        poll(1'b0, 32'h0000_1000);
        poll(1'b0, 32'h0000_1000 + 32'd65534);
        poll(1'b0, 32'h0000_1000 + 32'd65535);

        // directed: polarity flipped while a level is held
        wait_idle();
        write_polarity(1'b1);
        poll(1'b0, 32'h0000_1000 + 32'd131070);
        poll(1'b0, 32'h0000_1000 + 32'd196605);

        // random phases, each with its own config and idle pattern
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_idle();
            case (ph % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 68; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_DEBOUNCE_MS, pick_ms());
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_LONG_PRESS_MS, pick_ms());
            if ($urandom_range(0, 1) != 0)
                write_polarity(1'($urandom));
            if ($urandom_range(0, 3) == 0)
                t_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);  // run across the wrap
            goal = queued_polls + POLLS_PHASE;
            while (queued_polls < goal)
            begin
                if ($urandom_range(0, 99) < 80)
                    press_cycle();
                else
                    noise_burst();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_events.size() != 0)
        begin
            fail_count += expected_events.size();
            $display("%0d expected results never arrived", expected_events.size());
        end

        $display("ran %0d polls and %0d register writes over %0d idle/stall phases",
                 polls_done, cfg_writes, RAND_PHASES + 1);
        $display("saw %0d short and %0d long presses, %0d failures",
                 short_seen, long_seen, fail_count);
        if (fail_count == 0)
            $display("button_debounce_long_press_core_tb: done, clean");
        else
            $display("button_debounce_long_press_core_tb: done, errors");
        $finish;
    end

endmodule
